@@ rtl/core/qmr_pkg.sv @@
// shared constants, types and op codes of the quaternion multiply / rotate unit
package qmr_pkg;

  localparam int unsigned ANGLE_BITS = 12;
  localparam int unsigned FRAC_BITS  = 14;
  localparam int unsigned COMP_W     = 16;

  // quarter-wave index, 0 .. 2^(ANGLE_BITS-2) inclusive
  localparam int unsigned QIDX_W = ANGLE_BITS - 1;
  // sine / cosine magnitude, 0 .. 2^FRAC_BITS inclusive
  localparam int unsigned MAG_W  = FRAC_BITS + 1;
  localparam int unsigned TRIG_W = FRAC_BITS + 2;
  // second multiplicand of the hamilton product (b, or scaled axis and cosine)
  localparam int unsigned OPND_W = (COMP_W + 1 > FRAC_BITS + 2) ? COMP_W + 1 : FRAC_BITS + 2;
  localparam int unsigned AXP_W  = COMP_W + TRIG_W;
  localparam int unsigned PROD_W = COMP_W + OPND_W;
  localparam int unsigned SUM_W  = PROD_W + 3;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_ROT  = 2'd1,
    OP_CONJ = 2'd2
  } qmr_op_e;

  typedef logic signed [COMP_W-1:0]     comp_t;
  typedef logic signed [TRIG_W-1:0]     trig_t;
  typedef logic signed [OPND_W-1:0]     opnd_t;
  typedef logic signed [ANGLE_BITS-1:0] angle_t;

  // component order is x, y, z, w at index 0 .. 3
  typedef struct packed {
    logic [1:0]  op;
    comp_t [3:0] a;
    comp_t [3:0] b;
    angle_t      angle;
  } qmr_req_t;

  typedef struct packed {
    qmr_req_t req;
    trig_t    s;
    trig_t    c;
  } qmr_trig_t;

  typedef struct packed {
    logic [1:0]  op;
    comp_t [3:0] a;
    opnd_t [3:0] bo;
  } qmr_opnd_t;

  typedef struct packed {
    comp_t [3:0] q;
  } qmr_rsp_t;

endpackage

@@ rtl/core/qmr_req_if.sv @@
// request channel of the quaternion unit: valid / ready and one input beat
interface qmr_req_if import qmr_pkg::*; ();

  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  comp_t      a_x;
  comp_t      a_y;
  comp_t      a_z;
  comp_t      a_w;
  comp_t      b_x;
  comp_t      b_y;
  comp_t      b_z;
  comp_t      b_w;
  angle_t     angle;

  modport source (
    output valid, req_type, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, angle,
    input  ready
  );

  modport sink (
    input  valid, req_type, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, angle,
    output ready
  );

endinterface

@@ rtl/core/qmr_rsp_if.sv @@
// response channel of the quaternion unit: valid / ready and one result beat
interface qmr_rsp_if import qmr_pkg::*; ();

  logic  valid;
  logic  ready;
  comp_t out_x;
  comp_t out_y;
  comp_t out_z;
  comp_t out_w;

  modport source (
    output valid, out_x, out_y, out_z, out_w,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z, out_w,
    output ready
  );

endinterface

@@ rtl/core/qmr_trig.sv @@
// sine / cosine pipeline: octant reduction, banked quarter-wave rom, unfold
module qmr_trig import qmr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  qmr_req_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output qmr_trig_t out_data_o
);

  localparam int unsigned QTR_W     = ANGLE_BITS - 2;
  localparam int unsigned BANK_AW   = (QTR_W < 8) ? QTR_W : 8;
  localparam int unsigned BANK_ROWS = 2 ** BANK_AW;
  localparam int unsigned BSEL_W    = QIDX_W - BANK_AW;
  localparam int unsigned NUM_BANKS = 2 ** (QTR_W - BANK_AW) + 1;
  localparam int unsigned ROM_W     = 2 * MAG_W;

  localparam logic [QIDX_W-1:0]     QUARTER = {1'b1, {QTR_W{1'b0}}};
  localparam logic [ANGLE_BITS-1:0] HALF    = {1'b1, {(ANGLE_BITS-1){1'b0}}};
  localparam trig_t                 ONE     = trig_t'(1) << FRAC_BITS;

  localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
  localparam logic [63:0] PI_Q62  = 64'hC90F_DAA2_2168_C235;

  // taylor divisors (n+1)(n+2) for the sine and cosine series
  localparam logic [11:0] SIN_DIV [24] = '{
    12'd6,    12'd20,   12'd42,   12'd72,   12'd110,  12'd156,  12'd210,  12'd272,
    12'd342,  12'd420,  12'd506,  12'd600,  12'd702,  12'd812,  12'd930,  12'd1056,
    12'd1190, 12'd1332, 12'd1482, 12'd1640, 12'd1806, 12'd1980, 12'd2162, 12'd2352
  };
  localparam logic [11:0] COS_DIV [24] = '{
    12'd2,    12'd12,   12'd30,   12'd56,   12'd90,   12'd132,  12'd182,  12'd240,
    12'd306,  12'd380,  12'd462,  12'd552,  12'd650,  12'd756,  12'd870,  12'd992,
    12'd1122, 12'd1260, 12'd1406, 12'd1560, 12'd1722, 12'd1892, 12'd2070, 12'd2256
  };

  typedef logic [ROM_W-1:0] rom_word_t;

  typedef struct packed {
    qmr_req_t          req;
    logic [QIDX_W-1:0] j;
    logic              swap;
    logic              neg;
  } st1_t;

  typedef struct packed {
    qmr_req_t                    req;
    logic [BSEL_W-1:0]           bsel;
    rom_word_t [NUM_BANKS-1:0]   words;
    logic                        swap;
    logic                        neg;
  } st2_t;

  // rom contents, worked out at elaboration in q62 fixed point
  function automatic logic [63:0] mul_q62(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return p[125:62];
  endfunction

  function automatic logic [63:0] series_q62(input logic [63:0] x, input logic odd);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = mul_q62(x, x);
    term = odd ? x : Q62_ONE;
    sum  = term;
    for (int i = 0; i < 24; i++) begin
      if (odd) begin
        term = mul_q62(term, x2) / SIN_DIV[i];
      end else begin
        term = mul_q62(term, x2) / COS_DIV[i];
      end
      if (i[0]) begin
        sum = sum + term;
      end else begin
        sum = sum - term;
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] round_q62(input logic [63:0] v);
    return (v + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
  endfunction

  function automatic rom_word_t rom_word(input int unsigned idx);
    logic [63:0] th;
    logic [63:0] sv;
    logic [63:0] cv;
    th = mul_q62(PI_Q62, 64'(idx) << (62 - ANGLE_BITS));
    sv = round_q62(series_q62(th, 1'b1));
    cv = round_q62(series_q62(th, 1'b0));
    return {sv[MAG_W-1:0], cv[MAG_W-1:0]};
  endfunction

  function automatic logic [BANK_ROWS*ROM_W-1:0] build_bank(input int unsigned bank);
    logic [BANK_ROWS*ROM_W-1:0] w;
    w = '0;
    for (int unsigned r = 0; r < BANK_ROWS; r++) begin
      w[r*ROM_W +: ROM_W] = rom_word(bank * BANK_ROWS + r);
    end
    return w;
  endfunction

  logic [2:0] vld_q;
  logic [2:0] rdy;
  st1_t       st1_d, st1_q;
  st2_t       st2_d, st2_q;
  qmr_trig_t  st3_d, st3_q;

  assign rdy[2]      = !vld_q[2] || out_ready_i;
  assign rdy[1]      = !vld_q[1] || rdy[2];
  assign rdy[0]      = !vld_q[0] || rdy[1];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[2];
  assign out_data_o  = st3_q;

  // stage 1: fold the angle into the first octant
  logic [ANGLE_BITS-1:0] k;
  logic [ANGLE_BITS-1:0] j_full;
  always_comb begin
    st1_d.req  = in_data_i;
    st1_d.neg  = in_data_i.angle[ANGLE_BITS-1];
    k          = st1_d.neg ? ANGLE_BITS'(0) - in_data_i.angle : in_data_i.angle;
    st1_d.swap = k > {1'b0, QUARTER};
    j_full     = st1_d.swap ? HALF - k : k;
    st1_d.j    = j_full[QIDX_W-1:0];
  end

  // stage 2: read every bank at the row address
  logic [BANK_AW-1:0] row;
  assign row = st1_q.j[BANK_AW-1:0];

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    localparam logic [BANK_ROWS*ROM_W-1:0] BANK_ROM = build_bank(g);
    assign st2_d.words[g] = BANK_ROM[row*ROM_W +: ROM_W];
  end

  assign st2_d.req  = st1_q.req;
  assign st2_d.bsel = st1_q.j[QIDX_W-1:BANK_AW];
  assign st2_d.swap = st1_q.swap;
  assign st2_d.neg  = st1_q.neg;

  // stage 3: pick the bank, undo the octant fold
  rom_word_t        word;
  logic [MAG_W-1:0] s_mag;
  logic [MAG_W-1:0] c_mag;
  always_comb begin
    word = '0;
    for (int g = 0; g < NUM_BANKS; g++) begin
      if (st2_q.bsel == BSEL_W'(g)) begin
        word = st2_q.words[g];
      end
    end
    if (st2_q.swap) begin
      s_mag = word[MAG_W-1:0];
      c_mag = word[ROM_W-1:MAG_W];
    end else begin
      s_mag = word[ROM_W-1:MAG_W];
      c_mag = word[MAG_W-1:0];
    end
    st3_d.req = st2_q.req;
    st3_d.s   = st2_q.neg ? -trig_t'({1'b0, s_mag}) : trig_t'({1'b0, s_mag});
    st3_d.c   = trig_t'({1'b0, c_mag});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) st1_q <= st1_d;
    if (rdy[1] && vld_q[0])   st2_q <= st2_d;
    if (rdy[2] && vld_q[1])   st3_q <= st3_d;
  end

  a_octant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> st1_q.j <= QUARTER)
    else $error("folded angle beyond the first octant");

  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (st3_q.c >= 0 && st3_q.c <= ONE && st3_q.s <= ONE && st3_q.s >= -ONE))
    else $error("sine or cosine out of range");

endmodule

@@ rtl/core/qmr_axis.sv @@
// axis scaling pipeline: axis times sine, rounding, operand select
module qmr_axis import qmr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  qmr_trig_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output qmr_opnd_t out_data_o
);

  typedef logic signed [AXP_W-1:0] axp_t;
  typedef logic signed [AXP_W:0]   axr_t;

  localparam axr_t HALF = axr_t'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    qmr_req_t   req;
    trig_t      c;
    axp_t [2:0] p;
  } st4_t;

  logic [1:0] vld_q;
  logic [1:0] rdy;
  st4_t       st4_d, st4_q;
  qmr_opnd_t  st5_d, st5_q;

  assign rdy[1]      = !vld_q[1] || out_ready_i;
  assign rdy[0]      = !vld_q[0] || rdy[1];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[1];
  assign out_data_o  = st5_q;

  // stage 4: axis components times sine
  always_comb begin
    st4_d.req = in_data_i.req;
    st4_d.c   = in_data_i.c;
    for (int i = 0; i < 3; i++) begin
      st4_d.p[i] = axp_t'(in_data_i.req.b[i]) * axp_t'(in_data_i.s);
    end
  end

  // stage 5: round half up, then build the second multiplicand
  axr_t [2:0] r;
  always_comb begin
    st5_d.op = st4_q.req.op;
    st5_d.a  = st4_q.req.a;
    for (int i = 0; i < 3; i++) begin
      r[i] = (axr_t'(st4_q.p[i]) + HALF) >>> FRAC_BITS;
    end
    if (st4_q.req.op == OP_ROT) begin
      for (int i = 0; i < 3; i++) begin
        st5_d.bo[i] = opnd_t'(r[i]);
      end
      st5_d.bo[3] = opnd_t'(st4_q.c);
    end else begin
      for (int i = 0; i < 4; i++) begin
        st5_d.bo[i] = opnd_t'(st4_q.req.b[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) st4_q <= st4_d;
    if (rdy[1] && vld_q[0])   st5_q <= st5_d;
  end

endmodule

@@ rtl/core/qmr_mac.sv @@
// hamilton product pipeline: sixteen products, four sums, round and saturate
module qmr_mac import qmr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  qmr_opnd_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output qmr_rsp_t  out_data_o
);

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam sum_t HALF     = sum_t'(1) << (FRAC_BITS - 1);
  localparam sum_t COMP_MAX = sum_t'({1'b0, {(COMP_W-1){1'b1}}});
  localparam sum_t COMP_MIN = -COMP_MAX - sum_t'(1);

  typedef struct packed {
    logic [1:0]        op;
    comp_t [3:0]       a;
    prod_t [3:0][3:0]  p;
  } st6_t;

  typedef struct packed {
    logic [1:0]  op;
    comp_t [3:0] a;
    sum_t [3:0]  s;
  } st7_t;

  function automatic comp_t sat(input sum_t v);
    sum_t t;
    if (v > COMP_MAX) begin
      t = COMP_MAX;
    end else if (v < COMP_MIN) begin
      t = COMP_MIN;
    end else begin
      t = v;
    end
    return comp_t'(t);
  endfunction

  logic [2:0] vld_q;
  logic [2:0] rdy;
  st6_t       st6_d, st6_q;
  st7_t       st7_d, st7_q;
  qmr_rsp_t   st8_d, st8_q;

  assign rdy[2]      = !vld_q[2] || out_ready_i;
  assign rdy[1]      = !vld_q[1] || rdy[2];
  assign rdy[0]      = !vld_q[0] || rdy[1];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[2];
  assign out_data_o  = st8_q;

  // stage 6: p[i][j] = a[i] * bo[j]
  always_comb begin
    st6_d.op = in_data_i.op;
    st6_d.a  = in_data_i.a;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        st6_d.p[i][j] = prod_t'(in_data_i.a[i]) * prod_t'(in_data_i.bo[j]);
      end
    end
  end

  // stage 7: component sums
  always_comb begin
    st7_d.op   = st6_q.op;
    st7_d.a    = st6_q.a;
    st7_d.s[0] = sum_t'(st6_q.p[3][0]) + sum_t'(st6_q.p[0][3])
               + sum_t'(st6_q.p[1][2]) - sum_t'(st6_q.p[2][1]);
    st7_d.s[1] = sum_t'(st6_q.p[3][1]) + sum_t'(st6_q.p[1][3])
               + sum_t'(st6_q.p[2][0]) - sum_t'(st6_q.p[0][2]);
    st7_d.s[2] = sum_t'(st6_q.p[3][2]) + sum_t'(st6_q.p[2][3])
               + sum_t'(st6_q.p[0][1]) - sum_t'(st6_q.p[1][0]);
    st7_d.s[3] = sum_t'(st6_q.p[3][3]) - sum_t'(st6_q.p[0][0])
               - sum_t'(st6_q.p[1][1]) - sum_t'(st6_q.p[2][2]);
  end

  // stage 8: round half up, saturate, pick the result by op
  sum_t [3:0] rnd;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rnd[i] = (st7_q.s[i] + HALF) >>> FRAC_BITS;
    end
    unique case (st7_q.op)
      OP_MUL, OP_ROT: begin
        for (int i = 0; i < 4; i++) begin
          st8_d.q[i] = sat(rnd[i]);
        end
      end
      OP_CONJ: begin
        for (int i = 0; i < 3; i++) begin
          st8_d.q[i] = sat(-sum_t'(st7_q.a[i]));
        end
        st8_d.q[3] = st7_q.a[3];
      end
      default: begin
        st8_d.q = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) st6_q <= st6_d;
    if (rdy[1] && vld_q[0])   st7_q <= st7_d;
    if (rdy[2] && vld_q[1])   st8_q <= st8_d;
  end

endmodule

@@ rtl/core/quaternion_multiply_rotate_top.sv @@
// top level of the quaternion multiply / rotate / conjugate unit
//
// Fixed-point quaternion unit on signed Q2.14 components laid out (x, y, z, w).
// req_type 0 returns the hamilton product a*b; req_type 1 rotates a about the
// axis (b_x, b_y, b_z) by angle (4096 units per full turn), multiplying a by
// (axis*sin, cos) of half that angle, with the axis used as given; req_type 2
// returns the conjugate of a; req_type 3 returns all zeros. Every sum of
// products is rounded half up at bit 14 and saturated to 16 bits. The unit
// takes one beat per clock unless back-pressure has filled every stage, and
// returns one result beat for each, in order. An accepted request beat passes
// through 3 stages of sine / cosine lookup (octant fold, banked quarter-wave
// rom read, unfold), 2 stages of axis scaling and 3 stages of 16 parallel
// multipliers, adders and the saturating output register. Every stage has
// its own valid bit and takes a new beat when it is empty or its successor
// moves, so bubbles are squeezed out and the request side keeps accepting
// while a result waits, until all 8 stages are full. There is no state
// beyond the pipeline, no configuration and no init pass.
module quaternion_multiply_rotate_top import qmr_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  qmr_req_if.sink        req_i,
  qmr_rsp_if.source      rsp_o
);

  qmr_req_t  req_data;
  qmr_trig_t trig_data;
  qmr_opnd_t opnd_data;
  qmr_rsp_t  rsp_data;

  logic trig_valid, trig_ready;
  logic opnd_valid, opnd_ready;

  // pack the request beat, index 0..3 is x, y, z, w
  always_comb begin
    req_data.op    = req_i.req_type;
    req_data.a     = {req_i.a_w, req_i.a_z, req_i.a_y, req_i.a_x};
    req_data.b     = {req_i.b_w, req_i.b_z, req_i.b_y, req_i.b_x};
    req_data.angle = req_i.angle;
  end

  // sine and cosine of the half angle, computed for every beat
  qmr_trig u_trig (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .in_data_i   (req_data),
    .out_valid_o (trig_valid),
    .out_ready_i (trig_ready),
    .out_data_o  (trig_data)
  );

  // scaled axis and cosine replace b in rotate mode
  qmr_axis u_axis (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (trig_valid),
    .in_ready_o  (trig_ready),
    .in_data_i   (trig_data),
    .out_valid_o (opnd_valid),
    .out_ready_i (opnd_ready),
    .out_data_o  (opnd_data)
  );

  // hamilton product, conjugate and output register
  qmr_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (opnd_valid),
    .in_ready_o  (opnd_ready),
    .in_data_i   (opnd_data),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_data_o  (rsp_data)
  );

  assign rsp_o.out_x = rsp_data.q[0];
  assign rsp_o.out_y = rsp_data.q[1];
  assign rsp_o.out_z = rsp_data.q[2];
  assign rsp_o.out_w = rsp_data.q[3];

  // the request side may only stall when every stage is full and the
  // result beat is held back
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (rsp_o.valid && !rsp_o.ready))
    else $error("request stalled while the pipeline has room");

endmodule

@@ test/tb_quaternion_multiply_rotate_top.sv @@
// self-checking testbench of the quaternion multiply / rotate / conjugate unit
`timescale 1ns / 100ps

module tb_quaternion_multiply_rotate_top import qmr_pkg::*; ();

  // req_type 3 is not in the package enum, the unit answers it with zeros
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam bit [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
  localparam bit [63:0] PI_Q62  = 64'hC90F_DAA2_2168_C235;

  localparam int HOLD_CYCLES = 300;  // long receiver hold-off, fills the pipeline
  localparam int DRAIN_CYCLES = 16;  // extra wait after the last expected result, catches stray beats
  localparam int MAX_REPORTS = 40;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  logic clk;
  logic rst_n;

  qmr_req_if req_if ();
  qmr_rsp_if rsp_if ();

  quaternion_multiply_rotate_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // expected result quaternions, oldest first
  qmr_rsp_t pending_quats[$];

  int       n_errors;
  int       n_results;
  rx_mode_e rx_mode;
  int       hold_token;   // bumped by the tests, each bump asks for one hold-off
  int       hold_seen;
  int       hold_left;
  int       rx_phase;

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop in case a handshake never completes
  initial begin
    #2_000_000;
    $display("tb_quaternion_multiply_rotate_top: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // (x*y) >> 62 on unsigned Q62 values, full 128-bit product
  function automatic bit [63:0] q62_mul(bit [63:0] x, bit [63:0] y);
    bit [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return p[125:62];
  endfunction

  // taylor series on [0, pi/4] in Q62, odd picks sine, else cosine
  function automatic bit [63:0] taylor_q62(bit [63:0] th, bit odd);
    bit [63:0] th2;
    bit [63:0] term;
    bit [63:0] sum;
    bit [63:0] n;
    int        i;
    th2  = q62_mul(th, th);
    term = odd ? th : Q62_ONE;
    sum  = term;
    n    = odd ? 64'd1 : 64'd0;
    // signs alternate, first correction term is subtracted
    for (i = 0; i < 24 && term != 64'd0; i++) begin
      term = q62_mul(term, th2) / ((n + 64'd1) * (n + 64'd2));
      n    = n + 64'd2;
      if (i % 2 == 0) sum = sum - term;
      else            sum = sum + term;
    end
    return sum;
  endfunction

  // Q62 down to FRAC_BITS fraction bits, rounded half up
  function automatic longint q62_to_frac(bit [63:0] v);
    bit [63:0] r;
    r = (v + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
    return longint'(r);
  endfunction

  // sine and cosine of pi*ang/2^ANGLE_BITS, folded onto the first octant
  function automatic void half_angle_trig(angle_t ang, output longint s, output longint c);
    bit [ANGLE_BITS-1:0] v;
    bit [63:0]           k;
    bit [63:0]           j;
    bit [63:0]           th;
    bit                  neg;
    bit                  swap;
    longint              sv;
    longint              cv;
    longint              t;
    v    = ang;
    neg  = v[ANGLE_BITS-1];
    k    = neg ? (64'd1 << ANGLE_BITS) - 64'(v) : 64'(v);
    swap = k > (64'd1 << (ANGLE_BITS - 2));
    j    = swap ? (64'd1 << (ANGLE_BITS - 1)) - k : k;
    th   = q62_mul(PI_Q62, j << (62 - ANGLE_BITS));
    sv   = q62_to_frac(taylor_q62(th, 1'b1));
    cv   = q62_to_frac(taylor_q62(th, 1'b0));
    if (swap) begin
      t  = sv;
      sv = cv;
      cv = t;
    end
    s = neg ? -sv : sv;
    c = cv;
  endfunction

  // floor((v + half lsb) / 2^FRAC_BITS)
  function automatic longint frac_round(longint v);
    return (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic comp_t clamp16(longint v);
    if (v > 32767)  return comp_t'(32767);
    if (v < -32768) return comp_t'(-32768);
    return comp_t'(v);
  endfunction

  // hamilton product, index 0..3 is x, y, z, w
  function automatic qmr_rsp_t hamilton_q(longint p[4], longint q[4]);
    qmr_rsp_t res;
    res.q[0] = clamp16(frac_round(p[3]*q[0] + p[0]*q[3] + p[1]*q[2] - p[2]*q[1]));
    res.q[1] = clamp16(frac_round(p[3]*q[1] + p[1]*q[3] + p[2]*q[0] - p[0]*q[2]));
    res.q[2] = clamp16(frac_round(p[3]*q[2] + p[2]*q[3] + p[0]*q[1] - p[1]*q[0]));
    res.q[3] = clamp16(frac_round(p[3]*q[3] - p[0]*q[0] - p[1]*q[1] - p[2]*q[2]));
    return res;
  endfunction

  function automatic qmr_rsp_t quat_result(qmr_req_t r);
    longint   qa[4];
    longint   qb[4];
    longint   s;
    longint   c;
    qmr_rsp_t res;
    int       i;
    for (i = 0; i < 4; i++) begin
      qa[i] = longint'(signed'(r.a[i]));
      qb[i] = longint'(signed'(r.b[i]));
    end
    case (r.op)
      OP_MUL: res = hamilton_q(qa, qb);
      OP_ROT: begin
        // axis scaled by the sine stays at full width, b_w is replaced by the cosine
        half_angle_trig(r.angle, s, c);
        for (i = 0; i < 3; i++) qb[i] = frac_round(qb[i] * s);
        qb[3] = c;
        res = hamilton_q(qa, qb);
      end
      OP_CONJ: begin
        // negating -32768 saturates
        res.q[0] = clamp16(-qa[0]);
        res.q[1] = clamp16(-qa[1]);
        res.q[2] = clamp16(-qa[2]);
        res.q[3] = clamp16(qa[3]);
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic qmr_req_t make_item(logic [1:0] op, int ax, int ay, int az, int aw,
                                         int bx, int by, int bz, int bw, int ang);
    qmr_req_t r;
    r.op    = op;
    r.a[0]  = comp_t'(ax);
    r.a[1]  = comp_t'(ay);
    r.a[2]  = comp_t'(az);
    r.a[3]  = comp_t'(aw);
    r.b[0]  = comp_t'(bx);
    r.b[1]  = comp_t'(by);
    r.b[2]  = comp_t'(bz);
    r.b[3]  = comp_t'(bw);
    r.angle = angle_t'(ang);
    return r;
  endfunction

  // mostly full-range values, with extremes and unit-sized values mixed in
  function automatic comp_t rand_comp();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 6))
        0: return comp_t'(-32768);
        1: return comp_t'(32767);
        2: return comp_t'(0);
        3: return comp_t'(16384);
        4: return comp_t'(-16384);
        5: return comp_t'(1);
        default: return comp_t'(-1);
      endcase
    end
    if (pick <= 3) return comp_t'(int'($urandom_range(0, 32768)) - 16384);
    return comp_t'($urandom);
  endfunction

  function automatic angle_t rand_angle();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 9))
        0: return angle_t'(0);
        1: return angle_t'(512);
        2: return angle_t'(1024);
        3: return angle_t'(1536);
        4: return angle_t'(-2048);
        5: return angle_t'(2047);
        6: return angle_t'(-1024);
        7: return angle_t'(-512);
        8: return angle_t'(1);
        default: return angle_t'(-1);
      endcase
    end
    return angle_t'($urandom);
  endfunction

  function automatic qmr_req_t rand_item();
    qmr_req_t r;
    int       i;
    int       pick;
    int       axis;
    for (i = 0; i < 4; i++) begin
      r.a[i] = rand_comp();
      r.b[i] = rand_comp();
    end
    r.angle = rand_angle();
    pick = $urandom_range(0, 99);
    if (pick < 35)      r.op = OP_MUL;
    else if (pick < 75) r.op = OP_ROT;
    else if (pick < 90) r.op = OP_CONJ;
    else                r.op = OP_NONE;
    // a third of the rotations use a signed unit axis, as in rotate-about-x/y/z
    if (r.op == OP_ROT && $urandom_range(0, 2) == 0) begin
      axis = $urandom_range(0, 2);
      for (i = 0; i < 3; i++) r.b[i] = '0;
      r.b[axis] = $urandom_range(0, 1) ? comp_t'(16384) : comp_t'(-16384);
    end
    return r;
  endfunction

  // one request beat, held until the unit takes it
  task automatic send_beat(qmr_req_t r);
    req_if.valid    <= 1'b1;
    req_if.req_type <= r.op;
    req_if.a_x      <= r.a[0];
    req_if.a_y      <= r.a[1];
    req_if.a_z      <= r.a[2];
    req_if.a_w      <= r.a[3];
    req_if.b_x      <= r.b[0];
    req_if.b_y      <= r.b[1];
    req_if.b_z      <= r.b[2];
    req_if.b_w      <= r.b[3];
    req_if.angle    <= r.angle;
    do @(posedge clk); while (!req_if.ready);
    pending_quats.push_back(quat_result(r));
  endtask

  // gap on the request side, junk payload while valid is low
  task automatic idle_cycles(int n);
    qmr_req_t junk;
    if (n > 0) begin
      junk = rand_item();
      req_if.valid    <= 1'b0;
      req_if.req_type <= junk.op;
      req_if.a_x      <= junk.a[0];
      req_if.b_w      <= junk.b[3];
      req_if.angle    <= junk.angle;
      repeat (n) @(posedge clk);
    end
  endtask

  // random bursts with random gaps in between, a quarter of the bursts run back-to-back
  task automatic send_bursts(int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      left -= burst;
      repeat (burst) send_beat(rand_item());
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
    end
  endtask

  task automatic report_error(string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: ready pattern plus the long hold-off
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen    <= hold_token;
      hold_left    <= HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_RANDOM:   rsp_if.ready <= ($urandom_range(0, 99) < 65);
        RX_PERIODIC: rsp_if.ready <= ((rx_phase % 7) < 4);
        default:     rsp_if.ready <= 1'b1;
      endcase
    end
    rx_phase <= rx_phase + 1;
  end

  // ---------------------------------------------------------------------------
  // result checker: every result beat against the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    qmr_rsp_t want;
    comp_t    got[4];
    string    names[4];
    int       i;
    names = '{"out_x", "out_y", "out_z", "out_w"};
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.out_x, rsp_if.out_y, rsp_if.out_z, rsp_if.out_w};
      if (pending_quats.size() == 0) begin
        report_error($sformatf("result beat %0d arrived with nothing expected", n_results));
      end else begin
        want = pending_quats.pop_front();
        for (i = 0; i < 4; i++) begin
          if (got[i] !== want.q[i])
            report_error($sformatf("result beat %0d %s got %0d expected %0d",
                                   n_results, names[i], got[i], want.q[i]));
        end
      end
      n_results++;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes of every field, every op, octant folds and saturation cases
  task automatic test_directed();
    rx_mode = RX_ALWAYS;
    // hamilton product at the corners, sums past the 16-bit range saturate
    send_beat(make_item(OP_MUL, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0));
    send_beat(make_item(OP_MUL, -32768, -32768, -32768, -32768,
                        -32768, -32768, -32768, -32768, 0));
    send_beat(make_item(OP_MUL, -32768, -32768, -32768, -32768,
                        32767, 32767, 32767, 32767, -1));
    // product with the identity quaternion
    send_beat(make_item(OP_MUL, 1234, -5678, 9, -16384, 0, 0, 0, 16384, 2047));
    // rounding ties: one lsb times a half
    send_beat(make_item(OP_MUL, 1, -1, 1, -1, 8192, 8192, -8192, 8192, 0));
    // rotations: zero angle, quarter, half turn either way, octant boundaries
    send_beat(make_item(OP_ROT, 16384, 0, 0, 0, 16384, 0, 0, -32768, 0));
    send_beat(make_item(OP_ROT, 0, 16384, 0, 16384, 0, 16384, 0, 32767, 1024));
    send_beat(make_item(OP_ROT, 100, 200, 300, 16384, 0, 0, 16384, 0, 2047));
    send_beat(make_item(OP_ROT, -300, 200, -100, 16384, 0, 0, -16384, 0, -2048));
    send_beat(make_item(OP_ROT, 5000, -5000, 7000, 12000, 16384, 0, 0, 0, -1));
    send_beat(make_item(OP_ROT, 8000, 8000, 8000, 8000, 0, 16384, 0, 0, 512));
    send_beat(make_item(OP_ROT, -8000, 4000, 2000, 9000, 0, 0, 16384, 0, 1536));
    send_beat(make_item(OP_ROT, 11585, 0, 0, 11585, 16384, 0, 0, 0, -1024));
    // non-unit axis at full scale, scaled axis reaches 32768 unsaturated
    send_beat(make_item(OP_ROT, -32768, -32768, -32768, -32768,
                        -32768, -32768, -32768, 0, -2048));
    send_beat(make_item(OP_ROT, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0, 1024));
    send_beat(make_item(OP_ROT, 32767, -32768, 32767, -32768, -32768, 32767, -32768, 0, -512));
    // conjugate, negation of the most negative value saturates
    send_beat(make_item(OP_CONJ, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0));
    send_beat(make_item(OP_CONJ, 32767, 32767, 32767, -32768, -1, -1, -1, -1, -1));
    send_beat(make_item(OP_CONJ, 0, 1, -1, 0, 32767, 32767, 32767, 32767, 2047));
    // unused selector returns zeros whatever the operands
    send_beat(make_item(OP_NONE, 12345, -12345, 32767, -32768, 1, 2, 3, 4, 100));
    send_beat(make_item(OP_NONE, -1, -1, -1, -1, -1, -1, -1, -1, -1));
  endtask

  // one beat per clock both ways, no idling at all
  task automatic test_streaming();
    rx_mode = RX_ALWAYS;
    repeat (350) send_beat(rand_item());
  endtask

  // bursty sender, receiver alternating between random stalls and none
  task automatic test_bursty();
    int k;
    for (k = 0; k < 4; k++) begin
      rx_mode = (k % 2 == 0) ? RX_RANDOM : RX_ALWAYS;
      send_bursts(200);
    end
  endtask

  // receiver holds off long enough that all 8 stages fill and the request side stalls
  task automatic test_backpressure();
    rx_mode = RX_ALWAYS;
    hold_token++;
    repeat (60) send_beat(rand_item());
    rx_mode = RX_RANDOM;
    hold_token++;
    send_bursts(90);
  endtask

  // fixed ready pattern against random sender gaps
  task automatic test_rx_pattern();
    rx_mode = RX_PERIODIC;
    send_bursts(350);
  endtask

  initial begin
    n_errors   = 0;
    n_results  = 0;
    rx_mode    = RX_ALWAYS;
    hold_token = 0;
    hold_seen  = 0;
    hold_left  = 0;
    rx_phase   = 0;

    rst_n           = 1'b0;
    req_if.valid    = 1'b0;
    req_if.req_type = OP_MUL;
    req_if.a_x      = '0;
    req_if.a_y      = '0;
    req_if.a_z      = '0;
    req_if.a_w      = '0;
    req_if.b_x      = '0;
    req_if.b_y      = '0;
    req_if.b_z      = '0;
    req_if.b_w      = '0;
    req_if.angle    = '0;
    rsp_if.ready    = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_directed();
    test_streaming();
    test_bursty();
    test_backpressure();
    test_rx_pattern();

    // drain: stop offering beats, let every expected result come back
    req_if.valid <= 1'b0;
    rx_mode = RX_ALWAYS;
    while (pending_quats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("tb_quaternion_multiply_rotate_top: clean");
    end else begin
      $display("tb_quaternion_multiply_rotate_top: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/qmr_pkg.sv
rtl/core/qmr_req_if.sv
rtl/core/qmr_rsp_if.sv
rtl/core/qmr_trig.sv
rtl/core/qmr_axis.sv
rtl/core/qmr_mac.sv
rtl/core/quaternion_multiply_rotate_top.sv
test/tb_quaternion_multiply_rotate_top.sv
